### rtl/bsrp_pkg.sv
package bsrp_pkg;

	localparam int MAX_LEN = 256;

	localparam int LEN_W  = 9;
	localparam int WIDE_W = LEN_W + 4;

	localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(256);

	localparam logic [2:0] PH_EMPTY    = 3'd0;
	localparam logic [2:0] PH_LENGTH   = 3'd1;
	localparam logic [2:0] PH_AWAIT_LF = 3'd2;
	localparam logic [2:0] PH_PAYLOAD  = 3'd3;
	localparam logic [2:0] PH_COMPLETE = 3'd4;
	localparam logic [2:0] PH_FAILED   = 3'd5;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;

	localparam logic [WIDE_W-1:0] RADIX = WIDE_W'(10);

	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	typedef struct packed {
		logic [2:0]       phase;
		logic [LEN_W-1:0] pos;
		logic [LEN_W-1:0] dl;
		logic             digit_seen;
		logic             minus_seen;
		logic             null_flag;
	} parse_state_t;

	typedef struct packed {
		logic [2:0]       phase;
		logic             data_valid;
		logic [7:0]       data_byte;
		logic [7:0]       data_index;
		logic             last;
		logic [LEN_W-1:0] content_length;
		logic             null_reply;
	} result_t;

endpackage

### rtl/bsrp_step.sv
module bsrp_step import bsrp_pkg::*; (
	input  parse_state_t     cur,
	input  logic             kind,
	input  logic [7:0]       rx_byte,
	input  logic [LEN_W-1:0] deliver_limit,
	output parse_state_t     nxt,
	output result_t          res
);

	logic [WIDE_W-1:0] dl_wide;
	logic [LEN_W-1:0]  pos_inc;
	logic              is_digit;
	logic              pay_valid;
	logic              pay_last;

	assign dl_wide   = {{(WIDE_W-LEN_W){1'b0}}, cur.dl} * RADIX
	                 + {{(WIDE_W-4){1'b0}}, rx_byte[3:0]};
	assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign pos_inc   = cur.pos + LEN_W'(1);
	assign pay_valid = cur.pos < deliver_limit;
	assign pay_last  = pos_inc >= cur.dl;

	always_comb begin
		nxt            = cur;
		res            = '0;
		if (kind == KIND_RESTART) begin
			nxt = '0;
			nxt.phase = PH_EMPTY;
		end else begin
			unique case (cur.phase)
				PH_EMPTY: begin
					nxt.phase = (rx_byte == CH_DOLLAR) ? PH_LENGTH : PH_FAILED;
				end
				PH_LENGTH: begin
					if (rx_byte == CH_CR) begin
						if (cur.minus_seen) begin
							if (cur.digit_seen) begin
								nxt.null_flag = 1'b1;
								nxt.phase     = PH_COMPLETE;
							end else begin
								nxt.phase = PH_FAILED;
							end
						end else if (!cur.digit_seen) begin
							nxt.phase = PH_FAILED;
						end else begin
							nxt.phase = PH_AWAIT_LF;
						end
					end else if (rx_byte == CH_MINUS && !cur.digit_seen && !cur.minus_seen) begin
						nxt.minus_seen = 1'b1;
					end else if (!is_digit) begin
						nxt.phase = PH_FAILED;
					end else if (cur.minus_seen) begin
						if (cur.digit_seen || rx_byte != CH_ONE) begin
							nxt.phase = PH_FAILED;
						end else begin
							nxt.digit_seen = 1'b1;
						end
					end else begin
						nxt.dl         = dl_wide[LEN_W-1:0];
						nxt.digit_seen = 1'b1;
						if (dl_wide > WIDE_W'(MAX_LEN)) begin
							nxt.phase = PH_FAILED;
						end
					end
				end
				PH_AWAIT_LF: begin
					nxt.pos = '0;
					if (rx_byte != CH_LF) begin
						nxt.phase = PH_FAILED;
					end else begin
						nxt.phase = (cur.dl == '0) ? PH_COMPLETE : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					res.data_byte  = rx_byte;
					res.data_index = cur.pos[7:0];
					res.data_valid = pay_valid;
					nxt.pos        = pos_inc;
					if (pay_last) begin
						res.last  = 1'b1;
						nxt.phase = PH_COMPLETE;
					end
				end
				default: begin
				end
			endcase
		end
		res.phase          = nxt.phase;
		res.content_length = nxt.dl;
		res.null_reply     = nxt.null_flag;
	end

endmodule

### rtl/bulk_string_reply_parser.sv
// Bulk string reply parser: '$', decimal length, CR, LF, then payload.
// Input channel (in_valid/in_ready) carries one request per byte: kind 0 is
// a received byte, kind 1 restarts the parser for a new reply.
// Output channel (out_valid/out_ready) returns exactly one result per
// request, in order: phase, payload byte with index and last flag,
// declared length and null-reply flag.
// deliver_limit is written with deliver_limit_we; the user must do so only
// while idle, which the block does not enforce. Payload bytes with index at
// or above it come out with data_valid low.
// Throughput: one request per cycle while in_ready is high, set by the
// combinational parse step between the state registers and the output register.
// A two-entry output (register plus skid) keeps in_ready high while one
// result waits; when the receiver stalls for longer, in_ready drops after
// the skid entry fills and rises again once the receiver drains it.
// Reset: parser returns to empty phase, deliver_limit to 256, both output
// entries empty.
module bulk_string_reply_parser import bsrp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             deliver_limit_we,
	input  logic [LEN_W-1:0] deliver_limit_wdata,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  logic [7:0]       rx_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       phase,
	output logic             data_valid,
	output logic [7:0]       data_byte,
	output logic [7:0]       data_index,
	output logic             last,
	output logic [LEN_W-1:0] content_length,
	output logic             null_reply
);

	parse_state_t     st_q;
	parse_state_t     st_nxt;
	result_t          res;
	result_t          out_q;
	result_t          skid_q;
	logic             out_v_q;
	logic             skid_v_q;
	logic [LEN_W-1:0] limit_q;
	logic             accept;
	logic             drain;

	assign in_ready = !skid_v_q;
	assign accept   = in_valid && in_ready;
	assign drain    = !out_v_q || out_ready;

	bsrp_step u_step (
		.cur           (st_q),
		.kind          (kind),
		.rx_byte       (rx_byte),
		.deliver_limit (limit_q),
		.nxt           (st_nxt),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (deliver_limit_we) begin
			limit_q <= deliver_limit_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (drain) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid      = out_v_q;
	assign phase          = out_q.phase;
	assign data_valid     = out_q.data_valid;
	assign data_byte      = out_q.data_byte;
	assign data_index     = out_q.data_index;
	assign last           = out_q.last;
	assign content_length = out_q.content_length;
	assign null_reply     = out_q.null_reply;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while output register empty");

	a_terminal_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_BYTE &&
		 (st_q.phase == PH_COMPLETE || st_q.phase == PH_FAILED)) |=> $stable(st_q))
		else $error("terminal phase changed without restart");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_PAYLOAD) |-> (st_q.pos < st_q.dl))
		else $error("payload position reached declared length");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_ready) |=> (out_v_q && $stable(out_q)))
		else $error("stalled result changed");

endmodule
